// ----- rtl/core/ellr_pkg.sv -----
// ----------------------------------------------------------------------------
// ellr_pkg
// Types, widths and codes shared by the ellipse outline rasterizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ellr_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned RAD_W   = 10;
  localparam int unsigned OFS_W   = 11;
  localparam int unsigned SQ_W    = 20;
  localparam int unsigned MB_W    = 16;
  localparam int unsigned PROD_W  = SQ_W + 1 + MB_W;
  localparam int unsigned DEC_W   = 40;
  localparam int unsigned MIR_W   = 2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [MIR_W-1:0] MIR_LAST = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ONE,
    PH_TWO,
    PH_DONE
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQA,
    ST_SQB,
    ST_INIT,
    ST_INIT_END,
    ST_STA,
    ST_STB,
    ST_STC,
    ST_STD,
    ST_STE,
    ST_SEAM,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COLOR_W-1:0] color;
    logic [OFS_W-1:0]   ox;
    logic [OFS_W-1:0]   oy;
    logic               is_pixel;
    logic               done;
  } job_t;

endpackage

`default_nettype wire

// ----- rtl/core/ellipse_outline_rasterizer.sv -----
// start transfer: busy through ST_SQA, ST_SQB, ST_INIT and ST_INIT_END, no results
// step transfer inside a region: busy from ST_STA to ST_STE (and ST_SEAM at the
//   region seam), then in ST_EMIT until the handoff; first pixel in the next cycle
// four pixels leave one per unstalled cycle, draining while the next item runs
// step after the figure ends: one empty result, busy in ST_EMIT until handed off
// async active-low reset clears the sequencer to idle, no pending results
// ----------------------------------------------------------------------------
// ellipse_outline_rasterizer
// Midpoint ellipse outline generator: one point per step transfer, emitted as
// four mirrored pixels, with a shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ellipse_outline_rasterizer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic [ellr_pkg::COORD_W-1:0]  center_x_i,
  input  wire logic [ellr_pkg::COORD_W-1:0]  center_y_i,
  input  wire logic [ellr_pkg::RAD_W-1:0]    radius_x_i,
  input  wire logic [ellr_pkg::RAD_W-1:0]    radius_y_i,
  input  wire logic [ellr_pkg::COLOR_W-1:0]  pen_color_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ellr_pkg::COORD_W-1:0]       pixel_x_o,
  output logic [ellr_pkg::COORD_W-1:0]       pixel_y_o,
  output logic [ellr_pkg::COLOR_W-1:0]       pixel_color_o,
  output logic                               pixel_valid_o,
  output logic                               figure_done_o,
  output logic                               last_of_step_o
);

  logic [ellr_pkg::SQ_W-1:0]           mul_a;
  logic signed [ellr_pkg::MB_W-1:0]    mul_b;
  logic signed [ellr_pkg::PROD_W-1:0]  prod;
  logic                                job_valid;
  logic                                job_ready;
  ellr_pkg::job_t                      job;

  ellr_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  ellr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .radius_x_i  (radius_x_i),
    .radius_y_i  (radius_y_i),
    .pen_color_i (pen_color_i),
    .prod_i      (prod),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  ellr_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_ready_o    (job_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_color_o  (pixel_color_o),
    .pixel_valid_o  (pixel_valid_o),
    .figure_done_o  (figure_done_o),
    .last_of_step_o (last_of_step_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/ellr_mul.sv -----
// ----------------------------------------------------------------------------
// ellr_mul
// Shared multiplier: unsigned square-term operand times signed small operand,
// product registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ellr_mul (
  input  wire logic                                clk_i,
  input  wire logic [ellr_pkg::SQ_W-1:0]           op_a_i,
  input  wire logic signed [ellr_pkg::MB_W-1:0]    op_b_i,
  output logic signed [ellr_pkg::PROD_W-1:0]       prod_o
);

  logic signed [ellr_pkg::SQ_W:0]     a_ext;
  logic signed [ellr_pkg::PROD_W-1:0] prod_d;
  logic signed [ellr_pkg::PROD_W-1:0] prod_q;

  assign a_ext  = $signed({1'b0, op_a_i});
  assign prod_d = a_ext * op_b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- rtl/core/ellr_seq.sv -----
// ----------------------------------------------------------------------------
// ellr_seq
// Sequencer and state registers: latches the figure, runs the midpoint
// decision updates through the shared multiplier, hands finished steps on.
// ----------------------------------------------------------------------------
`default_nettype none

module ellr_seq (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               cmd_i,
  input  wire logic [ellr_pkg::COORD_W-1:0]       center_x_i,
  input  wire logic [ellr_pkg::COORD_W-1:0]       center_y_i,
  input  wire logic [ellr_pkg::RAD_W-1:0]         radius_x_i,
  input  wire logic [ellr_pkg::RAD_W-1:0]         radius_y_i,
  input  wire logic [ellr_pkg::COLOR_W-1:0]       pen_color_i,
  input  wire logic signed [ellr_pkg::PROD_W-1:0] prod_i,
  output logic [ellr_pkg::SQ_W-1:0]               mul_a_o,
  output logic signed [ellr_pkg::MB_W-1:0]        mul_b_o,
  output logic                                    job_valid_o,
  output ellr_pkg::job_t                          job_o,
  input  wire logic                               job_ready_i
);

  ellr_pkg::state_e state_q, state_d;
  ellr_pkg::phase_e phase_q, phase_d;

  logic [ellr_pkg::OFS_W-1:0]          x_q, x_d, y_q, y_d;
  logic [ellr_pkg::OFS_W-1:0]          pox_q, pox_d, poy_q, poy_d;
  logic signed [ellr_pkg::DEC_W-1:0]   dec_q, dec_d;
  logic signed [ellr_pkg::PROD_W-1:0]  cmp_q, cmp_d;
  logic [ellr_pkg::SQ_W-1:0]           a2_q, a2_d, b2_q, b2_d;
  logic [ellr_pkg::COORD_W-1:0]        cx_q, cx_d, cy_q, cy_d;
  logic [ellr_pkg::RAD_W-1:0]          rx_q, rx_d, ry_q, ry_d;
  logic [ellr_pkg::COLOR_W-1:0]        color_q, color_d;
  logic                                done_q, done_d, pix_q, pix_d;

  logic                                accept;
  logic                                in_region;
  logic signed [ellr_pkg::DEC_W-1:0]   prod_ext;
  logic signed [ellr_pkg::DEC_W-1:0]   two_a2, two_b2;
  logic [ellr_pkg::OFS_W-1:0]          x_inc, y_inc;

  assign in_stall_o = (state_q != ellr_pkg::ST_IDLE);
  assign accept     = in_valid_i && (state_q == ellr_pkg::ST_IDLE);
  assign in_region  = (phase_q == ellr_pkg::PH_ONE) || (phase_q == ellr_pkg::PH_TWO);
  assign prod_ext   = {{(ellr_pkg::DEC_W - ellr_pkg::PROD_W){prod_i[ellr_pkg::PROD_W-1]}},
                       prod_i};
  assign two_a2     = $signed({{(ellr_pkg::DEC_W - ellr_pkg::SQ_W - 1){1'b0}}, a2_q, 1'b0});
  assign two_b2     = $signed({{(ellr_pkg::DEC_W - ellr_pkg::SQ_W - 1){1'b0}}, b2_q, 1'b0});
  assign x_inc      = x_q + 11'd1;
  assign y_inc      = y_q + 11'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ellr_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd_i == ellr_pkg::CMD_START) begin
            state_d = ellr_pkg::ST_SQA;
          end else if (in_region) begin
            state_d = ellr_pkg::ST_STA;
          end else begin
            state_d = ellr_pkg::ST_EMIT;
          end
        end
      end
      ellr_pkg::ST_SQA:      state_d = ellr_pkg::ST_SQB;
      ellr_pkg::ST_SQB:      state_d = ellr_pkg::ST_INIT;
      ellr_pkg::ST_INIT:     state_d = ellr_pkg::ST_INIT_END;
      ellr_pkg::ST_INIT_END: state_d = ellr_pkg::ST_IDLE;
      ellr_pkg::ST_STA:      state_d = ellr_pkg::ST_STB;
      ellr_pkg::ST_STB:      state_d = ellr_pkg::ST_STC;
      ellr_pkg::ST_STC:      state_d = ellr_pkg::ST_STD;
      ellr_pkg::ST_STD:      state_d = ellr_pkg::ST_STE;
      ellr_pkg::ST_STE: begin
        if ((phase_q == ellr_pkg::PH_ONE) && !(cmp_q <= prod_i)) begin
          state_d = ellr_pkg::ST_SEAM;
        end else begin
          state_d = ellr_pkg::ST_EMIT;
        end
      end
      ellr_pkg::ST_SEAM:     state_d = ellr_pkg::ST_EMIT;
      ellr_pkg::ST_EMIT: begin
        if (job_ready_i) begin
          state_d = ellr_pkg::ST_IDLE;
        end
      end
      default:               state_d = ellr_pkg::ST_IDLE;
    endcase
  end

  // datapath and multiplier operands
  always_comb begin
    phase_d = phase_q;
    x_d     = x_q;
    y_d     = y_q;
    pox_d   = pox_q;
    poy_d   = poy_q;
    dec_d   = dec_q;
    cmp_d   = cmp_q;
    a2_d    = a2_q;
    b2_d    = b2_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    color_d = color_q;
    done_d  = done_q;
    pix_d   = pix_q;
    mul_a_o = '0;
    mul_b_o = '0;
    job_valid_o = 1'b0;
    case (state_q)
      ellr_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd_i == ellr_pkg::CMD_START) begin
            cx_d    = center_x_i;
            cy_d    = center_y_i;
            rx_d    = radius_x_i;
            ry_d    = radius_y_i;
            color_d = pen_color_i;
          end else begin
            pox_d  = x_q;
            poy_d  = y_q;
            pix_d  = in_region;
            done_d = !in_region;
          end
        end
      end
      ellr_pkg::ST_SQA: begin
        mul_a_o = {10'd0, rx_q};
        mul_b_o = $signed({6'd0, rx_q});
      end
      ellr_pkg::ST_SQB: begin
        a2_d    = prod_i[ellr_pkg::SQ_W-1:0];
        mul_a_o = {10'd0, ry_q};
        mul_b_o = $signed({6'd0, ry_q});
      end
      ellr_pkg::ST_INIT: begin
        b2_d    = prod_i[ellr_pkg::SQ_W-1:0];
        mul_a_o = a2_q;
        mul_b_o = 16'sd1 - $signed({5'd0, ry_q, 1'b0});
      end
      ellr_pkg::ST_INIT_END: begin
        dec_d   = two_b2 + prod_ext;
        x_d     = '0;
        y_d     = {1'b0, ry_q};
        phase_d = ((rx_q == '0) || (ry_q == '0)) ? ellr_pkg::PH_DONE : ellr_pkg::PH_ONE;
      end
      ellr_pkg::ST_STA: begin
        if (phase_q == ellr_pkg::PH_ONE) begin
          mul_a_o = a2_q;
          mul_b_o = 16'sd4 - $signed({3'd0, y_q, 2'b00});
        end else begin
          mul_a_o = b2_q;
          mul_b_o = 16'sd4 - $signed({3'd0, x_q, 2'b00});
        end
      end
      ellr_pkg::ST_STB: begin
        if (phase_q == ellr_pkg::PH_ONE) begin
          if (!dec_q[ellr_pkg::DEC_W-1]) begin
            dec_d = dec_q + prod_ext;
            y_d   = y_q - 11'd1;
          end
          mul_a_o = b2_q;
          mul_b_o = $signed({3'd0, x_q, 2'b00}) + 16'sd6;
        end else begin
          if (!dec_q[ellr_pkg::DEC_W-1]) begin
            dec_d = dec_q + prod_ext;
            x_d   = x_q - 11'd1;
          end
          mul_a_o = a2_q;
          mul_b_o = $signed({3'd0, y_q, 2'b00}) + 16'sd6;
        end
      end
      ellr_pkg::ST_STC: begin
        dec_d = dec_q + prod_ext;
        if (phase_q == ellr_pkg::PH_ONE) begin
          x_d     = x_inc;
          mul_a_o = b2_q;
          mul_b_o = $signed({5'd0, x_inc});
        end else begin
          y_d     = y_inc;
          mul_a_o = a2_q;
          mul_b_o = $signed({5'd0, y_inc});
        end
      end
      ellr_pkg::ST_STD: begin
        cmp_d = prod_i;
        if (phase_q == ellr_pkg::PH_ONE) begin
          mul_a_o = a2_q;
          mul_b_o = $signed({5'd0, y_q});
        end else begin
          mul_a_o = b2_q;
          mul_b_o = $signed({5'd0, x_q});
        end
      end
      ellr_pkg::ST_STE: begin
        if (phase_q == ellr_pkg::PH_ONE) begin
          done_d = 1'b0;
          if (!(cmp_q <= prod_i)) begin
            phase_d = ellr_pkg::PH_TWO;
            x_d     = {1'b0, rx_q};
            y_d     = '0;
          end
          mul_a_o = b2_q;
          mul_b_o = 16'sd1 - $signed({5'd0, rx_q, 1'b0});
        end else begin
          done_d = !(cmp_q <= prod_i);
          if (!(cmp_q <= prod_i)) begin
            phase_d = ellr_pkg::PH_DONE;
          end
        end
      end
      ellr_pkg::ST_SEAM: begin
        dec_d = two_a2 + prod_ext;
      end
      ellr_pkg::ST_EMIT: begin
        job_valid_o = 1'b1;
      end
      default: begin
        job_valid_o = 1'b0;
      end
    endcase
  end

  assign job_o.cx       = cx_q;
  assign job_o.cy       = cy_q;
  assign job_o.color    = color_q;
  assign job_o.ox       = pox_q;
  assign job_o.oy       = poy_q;
  assign job_o.is_pixel = pix_q;
  assign job_o.done     = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ellr_pkg::ST_IDLE;
      phase_q <= ellr_pkg::PH_IDLE;
      x_q     <= '0;
      y_q     <= '0;
      pox_q   <= '0;
      poy_q   <= '0;
      dec_q   <= '0;
      cmp_q   <= '0;
      a2_q    <= '0;
      b2_q    <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      rx_q    <= '0;
      ry_q    <= '0;
      color_q <= '0;
      done_q  <= 1'b0;
      pix_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      x_q     <= x_d;
      y_q     <= y_d;
      pox_q   <= pox_d;
      poy_q   <= poy_d;
      dec_q   <= dec_d;
      cmp_q   <= cmp_d;
      a2_q    <= a2_d;
      b2_q    <= b2_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      rx_q    <= rx_d;
      ry_q    <= ry_d;
      color_q <= color_d;
      done_q  <= done_d;
      pix_q   <= pix_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ellr_out.sv -----
// ----------------------------------------------------------------------------
// ellr_out
// Result stage: holds one finished step and sends its four mirrored pixels,
// or the single empty result, one transfer per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module ellr_out (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          job_valid_i,
  input  wire ellr_pkg::job_t                job_i,
  output logic                               job_ready_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ellr_pkg::COORD_W-1:0]       pixel_x_o,
  output logic [ellr_pkg::COORD_W-1:0]       pixel_y_o,
  output logic [ellr_pkg::COLOR_W-1:0]       pixel_color_o,
  output logic                               pixel_valid_o,
  output logic                               figure_done_o,
  output logic                               last_of_step_o
);

  logic                            busy_q, busy_d;
  logic [ellr_pkg::MIR_W-1:0]      cnt_q, cnt_d;
  ellr_pkg::job_t                  job_q, job_d;

  logic [ellr_pkg::COORD_W-1:0]    ox, oy;
  logic                            last;

  assign job_ready_o = !busy_q;
  assign out_valid_o = busy_q;

  assign ox   = {{(ellr_pkg::COORD_W - ellr_pkg::OFS_W){1'b0}}, job_q.ox};
  assign oy   = {{(ellr_pkg::COORD_W - ellr_pkg::OFS_W){1'b0}}, job_q.oy};
  assign last = !job_q.is_pixel || (cnt_q == ellr_pkg::MIR_LAST);

  // mirror order: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
  always_comb begin
    if (job_q.is_pixel) begin
      pixel_x_o     = cnt_q[0] ? (job_q.cx - ox) : (job_q.cx + ox);
      pixel_y_o     = cnt_q[1] ? (job_q.cy - oy) : (job_q.cy + oy);
      pixel_color_o = job_q.color;
    end else begin
      pixel_x_o     = '0;
      pixel_y_o     = '0;
      pixel_color_o = '0;
    end
  end

  assign pixel_valid_o  = job_q.is_pixel;
  assign figure_done_o  = job_q.done;
  assign last_of_step_o = last;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    job_d  = job_q;
    if (!busy_q) begin
      if (job_valid_i) begin
        busy_d = 1'b1;
        cnt_d  = '0;
        job_d  = job_i;
      end
    end else if (!out_stall_i) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      job_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      job_q  <= job_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ellr_chk.sv -----
// ----------------------------------------------------------------------------
// ellr_chk
// Port-level checks for the ellipse outline rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ellr_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [ellr_pkg::COORD_W-1:0]  pixel_x_o,
  input wire logic [ellr_pkg::COORD_W-1:0]  pixel_y_o,
  input wire logic [ellr_pkg::COLOR_W-1:0]  pixel_color_o,
  input wire logic                          pixel_valid_o,
  input wire logic                          figure_done_o,
  input wire logic                          last_of_step_o
);

  // an empty result closes its step and reports the figure finished
  a_empty_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pixel_valid_o) |-> (figure_done_o && last_of_step_o))
    else $error("empty result without done and last");

  // an empty result carries zero payload
  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pixel_valid_o) |->
      (pixel_x_o == '0 && pixel_y_o == '0 && pixel_color_o == '0))
    else $error("empty result with nonzero payload");

  // every accepted transfer sets the input stall, as the sequencer leaves idle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a transfer");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(pixel_x_o) && $stable(pixel_y_o) &&
       $stable(last_of_step_o)))
    else $error("stalled result changed");

endmodule

bind ellipse_outline_rasterizer ellr_chk u_chk (.*);

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ellipse outline rasterizer. A queue of start and
// step commands is planned up front, then driven with random idle cycles on
// both channels. Every accepted command runs through a midpoint ellipse model
// that predicts the mirrored pixels, and each pixel transfer is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_FROM  = 1000;
  localparam int QUIET_TO    = 2000;
  localparam int RANDOM_CMDS = 360;
  localparam int TAIL_CYCLES = 20;

  typedef logic [ellr_pkg::COORD_W-1:0] coord_t;
  typedef logic [ellr_pkg::RAD_W-1:0]   radius_t;
  typedef logic [ellr_pkg::COLOR_W-1:0] color_t;

  typedef struct packed {
    logic    cmd;
    coord_t  cx;
    coord_t  cy;
    radius_t rx;
    radius_t ry;
    color_t  color;
  } ellipse_cmd_t;

  typedef struct {
    ellr_pkg::phase_e phase;
    longint           ox;
    longint           oy;
    longint           dec;
    longint           a2;
    longint           b2;
    longint           rx;
    longint           ry;
    coord_t           cx;
    coord_t           cy;
    color_t           color;
  } geom_t;

  typedef struct packed {
    logic   emits;
    logic   is_pixel;
    logic   done;
    coord_t ux;
    coord_t uy;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   valid;
    logic   done;
    logic   last;
  } pixel_t;

  logic         clk_i;
  logic         rst_ni;
  logic         in_valid  = 1'b0;
  logic         in_taken  = 1'b0;
  logic         out_stall = 1'b0;
  ellipse_cmd_t cmd_item  = '0;
  logic         in_stall;
  logic         out_valid;
  coord_t       pixel_x;
  coord_t       pixel_y;
  color_t       pixel_color;
  logic         pixel_valid;
  logic         figure_done;
  logic         last_of_step;

  ellipse_cmd_t ellipse_cmds[$];
  pixel_t       pending_pixels[$];
  geom_t        plan_geom;
  geom_t        live_geom;
  int           mismatches  = 0;
  int           cycle_count = 0;

  ellipse_outline_rasterizer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .cmd_i          (cmd_item.cmd),
    .center_x_i     (cmd_item.cx),
    .center_y_i     (cmd_item.cy),
    .radius_x_i     (cmd_item.rx),
    .radius_y_i     (cmd_item.ry),
    .pen_color_i    (cmd_item.color),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .pixel_color_o  (pixel_color),
    .pixel_valid_o  (pixel_valid),
    .figure_done_o  (figure_done),
    .last_of_step_o (last_of_step)
  );

  function automatic geom_t idle_geom();
    geom_t g;
    g.phase = ellr_pkg::PH_IDLE;
    g.ox    = 0;
    g.oy    = 0;
    g.dec   = 0;
    g.a2    = 0;
    g.b2    = 0;
    g.rx    = 0;
    g.ry    = 0;
    g.cx    = '0;
    g.cy    = '0;
    g.color = '0;
    return g;
  endfunction

  // one midpoint step, or the setup of a start: returns the point drawn before the update
  function automatic point_t trace_ellipse(inout geom_t g, input ellipse_cmd_t c);
    point_t p;
    longint x;
    longint y;
    p = '0;
    if (c.cmd == ellr_pkg::CMD_START) begin
      g.cx    = c.cx;
      g.cy    = c.cy;
      g.color = c.color;
      g.rx    = longint'(c.rx);
      g.ry    = longint'(c.ry);
      g.a2    = g.rx * g.rx;
      g.b2    = g.ry * g.ry;
      g.ox    = 0;
      g.oy    = g.ry;
      g.dec   = 2 * g.b2 + g.a2 * (1 - 2 * g.ry);
      g.phase = (g.rx == 0 || g.ry == 0) ? ellr_pkg::PH_DONE : ellr_pkg::PH_ONE;
      return p;
    end
    p.emits = 1'b1;
    if (g.phase != ellr_pkg::PH_ONE && g.phase != ellr_pkg::PH_TWO) begin
      p.done = 1'b1;
      return p;
    end
    x = g.ox;
    y = g.oy;
    p.is_pixel = 1'b1;
    p.ux = x[ellr_pkg::COORD_W-1:0];
    p.uy = y[ellr_pkg::COORD_W-1:0];
    if (g.phase == ellr_pkg::PH_ONE) begin
      if (g.dec >= 0) begin
        g.dec += 4 * g.a2 * (1 - y);
        y--;
      end
      g.dec += g.b2 * (4 * x + 6);
      x++;
      if (g.b2 * x > g.a2 * y) begin
        g.phase = ellr_pkg::PH_TWO;
        x = g.rx;
        y = 0;
        g.dec = 2 * g.a2 + g.b2 * (1 - 2 * g.rx);
      end
    end else begin
      if (g.dec >= 0) begin
        g.dec += 4 * g.b2 * (1 - x);
        x--;
      end
      g.dec += g.a2 * (4 * y + 6);
      y++;
      p.done = (g.a2 * y > g.b2 * x);
      if (p.done) g.phase = ellr_pkg::PH_DONE;
    end
    g.ox = x;
    g.oy = y;
    return p;
  endfunction

  task automatic plan(input logic cmd, input coord_t cx, input coord_t cy,
                      input radius_t rx, input radius_t ry, input color_t color);
    ellipse_cmd_t c;
    c = {cmd, cx, cy, rx, ry, color};
    ellipse_cmds.push_back(c);
    void'(trace_ellipse(plan_geom, c));
  endtask

  task automatic plan_step();
    plan(ellr_pkg::CMD_STEP, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom),
         radius_t'($urandom), color_t'($urandom));
  endtask

  task automatic plan_figure(input coord_t cx, input coord_t cy,
                             input radius_t rx, input radius_t ry,
                             input color_t color, input int max_steps,
                             input int extra);
    int n;
    plan(ellr_pkg::CMD_START, cx, cy, rx, ry, color);
    n = 0;
    while (n < max_steps && (plan_geom.phase == ellr_pkg::PH_ONE ||
                             plan_geom.phase == ellr_pkg::PH_TWO)) begin
      plan_step();
      n++;
    end
    repeat (extra) plan_step();
  endtask

  function automatic radius_t pick_radius();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 75) return radius_t'($urandom_range(1, 6));
    if (sel < 95) return radius_t'($urandom_range(7, 20));
    return radius_t'($urandom_range(21, 1023));
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // driver
  always @(negedge clk_i) begin
    logic quiet;
    quiet = cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (ellipse_cmds.size() != 0 && (quiet || $urandom_range(0, 99) >= 7)) begin
          in_valid <= 1'b1;
          cmd_item <= ellipse_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !quiet && $urandom_range(0, 99) < 7;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    point_t pt;
    pixel_t want;
    int     k;
    in_taken <= rst_ni && in_valid && !in_stall;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, actual %h %h %h %b %b %b",
                   $time, pixel_x, pixel_y, pixel_color, pixel_valid, figure_done,
                   last_of_step);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_x", want.x, pixel_x);
          check_field("pixel_y", want.y, pixel_y);
          check_field("pixel_color", want.color, pixel_color);
          check_field("pixel_valid", 16'(want.valid), 16'(pixel_valid));
          check_field("figure_done", 16'(want.done), 16'(figure_done));
          check_field("last_of_step", 16'(want.last), 16'(last_of_step));
        end
      end
      if (in_valid && !in_stall) begin
        pt = trace_ellipse(live_geom, cmd_item);
        if (pt.emits && !pt.is_pixel) begin
          pending_pixels.push_back({16'h0, 16'h0, 16'h0, 1'b0, 1'b1, 1'b1});
        end else if (pt.emits) begin
          for (k = 0; k < 4; k++) begin
            want.x     = k[0] ? live_geom.cx - pt.ux : live_geom.cx + pt.ux;
            want.y     = k[1] ? live_geom.cy - pt.uy : live_geom.cy + pt.uy;
            want.color = live_geom.color;
            want.valid = 1'b1;
            want.done  = pt.done;
            want.last  = (k == 3);
            pending_pixels.push_back(want);
          end
        end
      end
    end
  end

  initial begin
    int      n_directed;
    int      sel;
    int      max_steps;
    radius_t rx;
    radius_t ry;
    rst_ni = 1'b0;
    plan_geom = idle_geom();
    live_geom = idle_geom();

    // step before any start, then empty figures from a zero radius
    plan_step();
    plan_figure(16'h1234, 16'h4321, 10'd0, 10'd5, 16'h0F0F, 10, 1);
    plan_figure(16'hBEEF, 16'h0001, 10'd7, 10'd0, 16'hF0F0, 10, 1);
    // smallest figure at the origin, wrapping below zero, then a step after the end
    plan_figure(16'h0000, 16'h0000, 10'd1, 10'd1, 16'h0000, 99, 1);
    // largest radii at the top of the coordinate range
    plan_figure(16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023, 16'hFFFF, 3, 0);
    // full figure across both regions
    plan_figure(16'h8000, 16'h7FFF, 10'd2, 10'd3, 16'hA5A5, 99, 1);
    n_directed = ellipse_cmds.size();

    while (ellipse_cmds.size() < n_directed + RANDOM_CMDS) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        rx = pick_radius();
        ry = pick_radius();
        max_steps = (sel < 10) ? $urandom_range(0, 4) : 1000;
        if (rx > 20 || ry > 20) max_steps = $urandom_range(1, 6);
        plan_figure(coord_t'($urandom), coord_t'($urandom), rx, ry, color_t'($urandom),
                    max_steps, ($urandom_range(0, 3) == 0) ? 1 : 0);
      end else if (sel < 90) begin
        plan_step();
      end else begin
        plan(1'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
             radius_t'($urandom_range(0, 1023)), radius_t'($urandom_range(0, 1023)),
             color_t'($urandom));
      end
    end

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    while (ellipse_cmds.size() != 0 || in_valid || pending_pixels.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
